/* hdl/fedl_pkg.sv */
// Shared types and constants for the fault event dedup log.
// No dependencies; imported by every module of the block.
package fedl_pkg;

   localparam int DEV_W  = 8;
   localparam int CODE_W = 8;
   localparam int TIME_W = 32;
   localparam int WIN_W  = 16;
   localparam int IDX_W  = 4;
   localparam int LIM_W  = 5;
   localparam int CNT_W  = 5;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

   typedef enum logic [1:0] {
      KIND_REPORT = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } state_type;

   // one log entry as held in the ring memory
   typedef struct packed {
      logic [DEV_W-1:0]  device;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] time_ms;
   } entry_type;

   // per-request command to the log ring
   typedef struct packed {
      logic             push;
      logic             clear;
      logic             rd;
      logic [IDX_W-1:0] rd_index;
      logic [LIM_W-1:0] rd_limit;
   } log_cmd_type;

endpackage

/* hdl/fedl_slots.sv */
// Recent-device table: repeat suppression and slot refresh.
// Depends on fedl_pkg.
module fedl_slots
   import fedl_pkg::*;
#(
   parameter int ID_SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              report,
   input  logic              clear,
   input  logic [DEV_W-1:0]  device_id,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [WIN_W-1:0]  window_ms,
   output logic              report_ok
);

   localparam int SLOT_W = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;

   logic [DEV_W-1:0]  ids_ff   [ID_SLOTS];
   logic [TIME_W-1:0] times_ff [ID_SLOTS];

   logic [ID_SLOTS-1:0] hit;
   logic [ID_SLOTS-1:0] same_id;
   logic [ID_SLOTS-1:0] empty;
   logic [SLOT_W-1:0]   slot;
   logic                found;
   logic                commit;

   // all slots compared in parallel
   always_comb begin
      for (int i = 0; i < ID_SLOTS; i++) begin
         same_id[i] = (ids_ff[i] == device_id);
         empty[i]   = (times_ff[i] == '0);
         hit[i]     = !empty[i] && same_id[i] &&
                      ((now_ms - times_ff[i]) < TIME_W'(window_ms));
      end
   end

   // first matching id, else first empty slot, else slot 0
   always_comb begin
      slot  = '0;
      found = 1'b0;
      for (int i = 0; i < ID_SLOTS; i++) begin
         if (!found && same_id[i]) begin
            slot  = SLOT_W'(i);
            found = 1'b1;
         end
      end
      for (int i = 0; i < ID_SLOTS; i++) begin
         if (!found && empty[i]) begin
            slot  = SLOT_W'(i);
            found = 1'b1;
         end
      end
   end

   assign report_ok = (hit == '0);
   assign commit    = report && report_ok;

   always_ff @(posedge clock) begin
      for (int i = 0; i < ID_SLOTS; i++) begin
         if (reset) begin
            ids_ff[i]   <= '0;
            times_ff[i] <= '0;
         end else if (clear) begin
            times_ff[i] <= '0;
         end else if (commit && slot == SLOT_W'(i)) begin
            ids_ff[i]   <= device_id;
            times_ff[i] <= now_ms;
         end
      end
   end

endmodule

/* hdl/fedl_log.sv */
// Bounded event log: ring memory with head pointer and fill count.
// Depends on fedl_pkg.
module fedl_log
   import fedl_pkg::*;
#(
   parameter int LOG_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  log_cmd_type       cmd,
   input  entry_type         wr_entry,
   output logic              rd_valid,
   output entry_type         rd_entry,
   output logic [CNT_W-1:0]  count
);

   localparam int AW    = $clog2(LOG_DEPTH);
   localparam int FW    = $clog2(LOG_DEPTH + 1);
   localparam int SUM_W = ((AW > IDX_W) ? AW : IDX_W) + 1;
   localparam int CMP_W = (FW > LIM_W) ? FW : LIM_W;

   entry_type mem [LOG_DEPTH];

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          rd_valid_ff, rd_valid_in;
   entry_type     rd_entry_ff;

   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          full;

   function automatic logic [AW-1:0] wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] adj;
      adj = (sum >= SUM_W'(LOG_DEPTH)) ? sum - SUM_W'(LOG_DEPTH) : sum;
      return adj[AW-1:0];
   endfunction

   assign full = (fill_ff == FW'(LOG_DEPTH));

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      wr_addr = head_ff;
      if (cmd.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (cmd.push) begin
         if (full) begin
            wr_addr = head_ff;
            head_in = wrap(SUM_W'(head_ff) + SUM_W'(1));
         end else begin
            wr_addr = wrap(SUM_W'(head_ff) + SUM_W'(fill_ff));
            fill_in = fill_ff + FW'(1);
         end
      end
   end

   // logical index -> ring position; index below fill keeps the sum under 2*depth
   always_comb begin
      rd_valid_in = cmd.rd &&
                    (CMP_W'(cmd.rd_index) < CMP_W'(fill_ff)) &&
                    (CMP_W'(cmd.rd_index) < CMP_W'(cmd.rd_limit));
      rd_addr     = rd_valid_in ? wrap(SUM_W'(head_ff) + SUM_W'(cmd.rd_index)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.rd) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_entry = rd_entry_ff;
   assign count    = CNT_W'(fill_ff);

endmodule

/* hdl/fault_event_dedup_log_top.sv */
// Top level of the fault event dedup log.
// Depends on fedl_pkg, fedl_slots and fedl_log.
//
// Usage
//  - Request channel: drive req_* and raise start; the request is taken at a
//    rising edge where start is high and busy is low.
//  - Kinds: report (dedup check, slot refresh, log append), read (one log
//    entry by logical position, oldest first), clear (empty the log, zero all
//    slot times), and an unused code that changes nothing.
//  - Response: exactly one per request, on rsp_* for one cycle with rsp_valid
//    high, in the cycle after the request is taken. The receiver cannot stall.
//  - Steps: as a request is taken, the slot compare, the table update and the
//    ring write or ring read are done; the response state then presents the
//    response with the registered log read data. busy is high in that state.
//  - Config: csr_repeat_window_ms is written when csr_valid and csr_ready are
//    both high; csr_ready is always high. Write only while idle.
//  - Reset: synchronous, active high. Slot ids and times go to zero, the log
//    becomes empty, the window returns to 1000 ms. No clearing pass is needed;
//    log entries are only read once written.
module fault_event_dedup_log_top
   import fedl_pkg::*;
#(
   parameter int ID_SLOTS  = 8,
   parameter int LOG_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [DEV_W-1:0]  req_device_id,
   input  logic [CODE_W-1:0] req_error_code,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [IDX_W-1:0]  req_read_index,
   input  logic [LIM_W-1:0]  req_read_limit,
   // response
   output logic              rsp_valid,
   output logic              rsp_accepted,
   output logic              rsp_entry_valid,
   output logic [DEV_W-1:0]  rsp_entry_device,
   output logic [CODE_W-1:0] rsp_entry_code,
   output logic [TIME_W-1:0] rsp_entry_time_ms,
   output logic [CNT_W-1:0]  rsp_event_count,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WIN_W-1:0]  csr_repeat_window_ms
);

   state_type state_ff, state_in;

   logic [WIN_W-1:0] window_ff;
   logic             accepted_ff, accepted_in;

   logic        take;
   kind_type    kind;
   logic        is_report;
   logic        is_read;
   logic        is_clear;
   logic        report_ok;
   log_cmd_type log_cmd;
   entry_type   wr_entry;
   logic        rd_valid;
   entry_type   rd_entry;
   logic [CNT_W-1:0] count;

   assign take = start && !busy;
   assign kind = kind_type'(req_kind);

   always_comb begin
      is_report = 1'b0;
      is_read   = 1'b0;
      is_clear  = 1'b0;
      unique case (kind)
         KIND_REPORT: is_report = take;
         KIND_READ:   is_read   = take;
         KIND_CLEAR:  is_clear  = take;
         KIND_NOP:    ;
      endcase
   end

   // repeat window register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_repeat_window_ms;
      end
   end

   // recent-device table
   fedl_slots #(
      .ID_SLOTS (ID_SLOTS)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .report    (is_report),
      .clear     (is_clear),
      .device_id (req_device_id),
      .now_ms    (req_now_ms),
      .window_ms (window_ff),
      .report_ok (report_ok)
   );

   // log ring: appended only when the report survives dedup
   always_comb begin
      log_cmd.push     = is_report && report_ok;
      log_cmd.clear    = is_clear;
      log_cmd.rd       = is_read;
      log_cmd.rd_index = req_read_index;
      log_cmd.rd_limit = req_read_limit;
      wr_entry.device  = req_device_id;
      wr_entry.code    = req_error_code;
      wr_entry.time_ms = req_now_ms;
   end

   fedl_log #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_log (
      .clock    (clock),
      .reset    (reset),
      .cmd      (log_cmd),
      .wr_entry (wr_entry),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .count    (count)
   );

   assign accepted_in = is_report && report_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
      end else if (take) begin
         accepted_ff <= accepted_in;
      end
   end

   // sequencer: idle -> response -> idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_RESP: begin
            busy      = 1'b1;
            rsp_valid = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // entry fields are zero unless the read was valid
   assign rsp_accepted      = accepted_ff;
   assign rsp_entry_valid   = rd_valid;
   assign rsp_entry_device  = rd_valid ? rd_entry.device  : '0;
   assign rsp_entry_code    = rd_valid ? rd_entry.code    : '0;
   assign rsp_entry_time_ms = rd_valid ? rd_entry.time_ms : '0;
   assign rsp_event_count   = count;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for fault_event_dedup_log_top: directed and random requests.
// Depends on fedl_pkg and the block's RTL; predicts every response with its own log model.
module testbench;
   import fedl_pkg::*;

   localparam int SLOTS       = 8;
   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;

   // one response as the block should present it
   typedef struct packed {
      logic              accepted;
      logic              entry_valid;
      logic [DEV_W-1:0]  device;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] time_ms;
      logic [CNT_W-1:0]  count;
   } log_answer;

   // Tracks the id table and the log ring, and queues the answer due per request.
   class fault_log_tracker;
      logic [WIN_W-1:0]  window;
      logic [DEV_W-1:0]  slot_id [SLOTS];
      logic [TIME_W-1:0] slot_time [SLOTS];
      entry_type         ring [DEPTH];
      logic [IDX_W-1:0]  head;
      logic [CNT_W-1:0]  fill;
      log_answer         due [$];
      int                mismatch_count;

      function new();
         window = WINDOW_RESET;
         foreach (slot_id[i]) begin
            slot_id[i]   = '0;
            slot_time[i] = '0;
         end
         foreach (ring[i]) ring[i] = '0;
         head           = '0;
         fill           = '0;
         mismatch_count = 0;
      endfunction

      function void flag(string what, logic [31:0] got, logic [31:0] want);
         mismatch_count++;
         if (mismatch_count <= 100)
            $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
      endfunction

      // dedup check, slot refresh and ring append; 1 when the report is logged
      function logic log_report(logic [DEV_W-1:0] dev, logic [CODE_W-1:0] code,
                                logic [TIME_W-1:0] now);
         int                pick;
         logic [TIME_W-1:0] age;
         logic [IDX_W-1:0]  pos;
         pick = -1;
         for (int i = 0; i < SLOTS; i++) begin
            age = now - slot_time[i];
            if (slot_time[i] != '0 && slot_id[i] == dev && age < 32'(window))
               return 1'b0;
         end
         // same id first, then an empty slot, else slot 0
         for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && slot_id[i] == dev) pick = i;
         for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && slot_time[i] == '0) pick = i;
         if (pick < 0) pick = 0;
         slot_id[pick]   = dev;
         slot_time[pick] = now;
         if (fill < DEPTH) begin
            pos = head + fill[IDX_W-1:0];
            fill++;
         end else begin
            pos = head;
            head++;
         end
         ring[pos] = '{device: dev, code: code, time_ms: now};
         return 1'b1;
      endfunction

      function void note_request(kind_type kind, logic [DEV_W-1:0] dev,
                                 logic [CODE_W-1:0] code, logic [TIME_W-1:0] now,
                                 logic [IDX_W-1:0] idx, logic [LIM_W-1:0] lim);
         log_answer        ans;
         logic [IDX_W-1:0] pos;
         ans = '0;
         case (kind)
            KIND_REPORT: ans.accepted = log_report(dev, code, now);
            KIND_READ: if (idx < fill && idx < lim) begin
               pos             = head + idx;
               ans.entry_valid = 1'b1;
               ans.device      = ring[pos].device;
               ans.code        = ring[pos].code;
               ans.time_ms     = ring[pos].time_ms;
            end
            KIND_CLEAR: begin
               fill = '0;
               head = '0;
               foreach (slot_time[i]) slot_time[i] = '0;
            end
            default: ;
         endcase
         ans.count = fill;
         due.push_back(ans);
      endfunction

      function void check_response(log_answer got);
         log_answer want;
         if (due.size() == 0) begin
            flag("response with no request outstanding", 0, 0);
            return;
         end
         want = due.pop_front();
         if (got.accepted !== want.accepted) flag("accepted", got.accepted, want.accepted);
         if (got.entry_valid !== want.entry_valid)
            flag("entry_valid", got.entry_valid, want.entry_valid);
         if (got.device !== want.device) flag("entry_device", got.device, want.device);
         if (got.code !== want.code) flag("entry_code", got.code, want.code);
         if (got.time_ms !== want.time_ms) flag("entry_time_ms", got.time_ms, want.time_ms);
         if (got.count !== want.count) flag("event_count", got.count, want.count);
      endfunction
   endclass

   logic              clock;
   logic              reset                = 1'b1;
   logic              start                = 1'b0;
   logic              busy;
   logic [1:0]        req_kind             = '0;
   logic [DEV_W-1:0]  req_device_id        = '0;
   logic [CODE_W-1:0] req_error_code       = '0;
   logic [TIME_W-1:0] req_now_ms           = '0;
   logic [IDX_W-1:0]  req_read_index       = '0;
   logic [LIM_W-1:0]  req_read_limit       = '0;
   logic              rsp_valid;
   logic              rsp_accepted;
   logic              rsp_entry_valid;
   logic [DEV_W-1:0]  rsp_entry_device;
   logic [CODE_W-1:0] rsp_entry_code;
   logic [TIME_W-1:0] rsp_entry_time_ms;
   logic [CNT_W-1:0]  rsp_event_count;
   logic              csr_valid            = 1'b0;
   logic              csr_ready;
   logic [WIN_W-1:0]  csr_repeat_window_ms = '0;

   fault_log_tracker tracker;
   int unsigned      cycle_count = 0;

   fault_event_dedup_log_top u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_device_id        (req_device_id),
      .req_error_code       (req_error_code),
      .req_now_ms           (req_now_ms),
      .req_read_index       (req_read_index),
      .req_read_limit       (req_read_limit),
      .rsp_valid            (rsp_valid),
      .rsp_accepted         (rsp_accepted),
      .rsp_entry_valid      (rsp_entry_valid),
      .rsp_entry_device     (rsp_entry_device),
      .rsp_entry_code       (rsp_entry_code),
      .rsp_entry_time_ms    (rsp_entry_time_ms),
      .rsp_event_count      (rsp_event_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_repeat_window_ms (csr_repeat_window_ms)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Monitor. All driving is nonblocking at the edge, so values seen here are the
   // ones the block samples at this same edge. The response is checked before the
   // next request is noted, though busy keeps the two on separate edges anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_response({rsp_accepted, rsp_entry_valid, rsp_entry_device,
                                    rsp_entry_code, rsp_entry_time_ms, rsp_event_count});
         if (start && !busy)
            tracker.note_request(kind_type'(req_kind), req_device_id, req_error_code,
                                 req_now_ms, req_read_index, req_read_limit);
         if (csr_valid && csr_ready)
            tracker.window = csr_repeat_window_ms;
      end
   end

   // Present one request and return at the edge that takes it. start stays high,
   // so a following request goes out back to back.
   task automatic issue(kind_type kind, logic [DEV_W-1:0] dev, logic [CODE_W-1:0] code,
                        logic [TIME_W-1:0] now, logic [IDX_W-1:0] idx,
                        logic [LIM_W-1:0] lim);
      start          <= 1'b1;
      req_kind       <= kind;
      req_device_id  <= dev;
      req_error_code <= code;
      req_now_ms     <= now;
      req_read_index <= idx;
      req_read_limit <= lim;
      do @(posedge clock); while (!(start && !busy));
   endtask

   // Random sender gap, so gaps land both in the idle state and in the response state.
   task automatic maybe_idle(int pct);
      if ($urandom_range(99, 0) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   // The first edge lets the monitor note the request taken at the calling edge.
   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.due.size() != 0) @(posedge clock);
   endtask

   // Window writes only with nothing in flight; the spare wait after the drain
   // lets the response of the last request go by.
   task automatic set_window(logic [WIN_W-1:0] value);
      hold_until_drained();
      repeat (2) @(posedge clock);
      csr_valid            <= 1'b1;
      csr_repeat_window_ms <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic directed_checks();
      // read of an empty log
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd0, 5'd16);
      // repeat inside the reset window is dropped, exactly one window later it is not
      issue(KIND_REPORT, 8'h05, 8'hA1, 32'd100, 4'd0, 5'd0);
      issue(KIND_REPORT, 8'h05, 8'hA2, 32'd500, 4'd0, 5'd0);
      issue(KIND_REPORT, 8'h05, 8'hA3, 32'd1100, 4'd0, 5'd0);
      // time zero marks a slot empty, so a repeat at time zero still gets in
      issue(KIND_REPORT, 8'h00, 8'h00, 32'd0, 4'd0, 5'd0);
      issue(KIND_REPORT, 8'h00, 8'h01, 32'd0, 4'd0, 5'd0);
      // dedup across the 32-bit wrap
      issue(KIND_REPORT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'd0, 5'd0);
      issue(KIND_REPORT, 8'hFF, 8'hFE, 32'h0000_0100, 4'd0, 5'd0);
      // unused kind with every field at its top
      issue(KIND_NOP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 5'h1F);
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd0, 5'd16);
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd1, 5'd1);    // blocked by the limit
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd4, 5'd0);    // zero limit
      // more ids than slots, and enough events to push the oldest out
      for (int i = 0; i < 12; i++)
         issue(KIND_REPORT, 8'(8'h20 + i), 8'(i), 32'(30000 + 100 * i), 4'd0, 5'd0);
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd15, 5'h1F);
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd0, 5'd16);
      issue(KIND_CLEAR, 8'h00, 8'h00, 32'd0, 4'd0, 5'd0);
      issue(KIND_READ, 8'h00, 8'h00, 32'd0, 4'd0, 5'd16);
      // zero window: nothing is ever dropped
      set_window('0);
      issue(KIND_REPORT, 8'd77, 8'h10, 32'd9, 4'd0, 5'd0);
      issue(KIND_REPORT, 8'd77, 8'h11, 32'd9, 4'd0, 5'd0);
   endtask

   // Mostly reports from a pool of ten ids (more than the slots hold), with time
   // steps scaled to the window so that both drops and refreshes are common.
   task automatic random_phase(int items, int idle_pct, logic [WIN_W-1:0] win);
      logic [DEV_W-1:0]  pool [10];
      logic [TIME_W-1:0] wall;
      logic [TIME_W-1:0] now;
      logic [DEV_W-1:0]  dev;
      logic [LIM_W-1:0]  lim;
      int                roll;
      int                span;
      set_window(win);
      foreach (pool[i]) pool[i] = 8'($urandom());
      wall = $urandom();
      span = int'(win) * 3 / 2 + 3;
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(99, 0);
         dev  = ($urandom_range(99, 0) < 75) ? pool[$urandom_range(9, 0)] : 8'($urandom());
         wall = wall + $urandom_range(span, 0);
         if ($urandom_range(49, 0) == 0) wall = $urandom();
         now  = ($urandom_range(39, 0) == 0) ? '0 : wall;
         lim  = ($urandom_range(3, 0) == 0) ? 5'($urandom()) : 5'(DEPTH);
         if (roll < 62)
            issue(KIND_REPORT, dev, 8'($urandom()), now, 4'($urandom()), 5'($urandom()));
         else if (roll < 92)
            issue(KIND_READ, dev, 8'($urandom()), now, 4'($urandom()), lim);
         else if (roll < 94)
            issue(KIND_CLEAR, dev, 8'($urandom()), now, 4'($urandom()), 5'($urandom()));
         else
            issue(KIND_NOP, dev, 8'($urandom()), now, 4'($urandom()), 5'($urandom()));
         // now and then the sender waits for every outstanding response
         if ($urandom_range(63, 0) == 0)
            hold_until_drained();
         else
            maybe_idle(idle_pct);
      end
   endtask

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      random_phase(400, 30, 16'hFFFF);
      random_phase(400, 73, 16'd1);
      random_phase(400, 0, 16'($urandom()));
      random_phase(400, 0, WINDOW_RESET);
      hold_until_drained();
      repeat (4) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.due.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* files.f */
hdl/fedl_pkg.sv
hdl/fedl_slots.sv
hdl/fedl_log.sv
hdl/fault_event_dedup_log_top.sv
test/testbench.sv
